[rtl/core/qrv_pkg.sv]
// Shared constants for the quaternion vector rotation pipeline.
// No dependencies; imported by the matrix, multiply-accumulate, top-level and checker files.
`default_nettype none

package qrv_pkg;

	// Integer bits of a quaternion part (Q2.14 at the default width).
	localparam int QUAT_INT_BITS = 2;

	// Extra bits of a rotation-matrix term over one quaternion product:
	// one for the four-term diagonal sum, one for the doubled off-diagonal.
	localparam int MAT_GROWTH = 2;

	// Extra bits of a three-term dot product over one matrix-times-offset product.
	localparam int SUM_GROWTH = 2;

endpackage

`default_nettype wire

[rtl/core/qrv_mat.sv]
// Stages 1 and 2: quaternion products, point-minus-pivot offset, rotation matrix.
// Depends on qrv_pkg.
`default_nettype none

module qrv_mat
	import qrv_pkg::*;
#(
	parameter int QW = 16,
	parameter int CW = 32,
	parameter int MW = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [QW-1:0] quat_w,
	input  wire logic signed [QW-1:0] quat_x,
	input  wire logic signed [QW-1:0] quat_y,
	input  wire logic signed [QW-1:0] quat_z,
	input  wire logic signed [CW-1:0] vec_x,
	input  wire logic signed [CW-1:0] vec_y,
	input  wire logic signed [CW-1:0] vec_z,
	input  wire logic signed [CW-1:0] pivot_x,
	input  wire logic signed [CW-1:0] pivot_y,
	input  wire logic signed [CW-1:0] pivot_z,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [MW-1:0]      mat [9],
	output logic signed [CW:0]        offs [3],
	output logic signed [CW-1:0]      piv [3]
);

	localparam int PW = 2 * QW;

	logic                 vld_s1, vld_s2;
	logic                 rdy_s1, rdy_s2;
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [CW:0]   offs_s1 [3];
	logic signed [CW-1:0] piv_s1 [3];
	logic signed [MW-1:0] mat_s2 [9];
	logic signed [CW:0]   offs_s2 [3];
	logic signed [CW-1:0] piv_s2 [3];

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	// Ten products of quaternion parts, offset of the point from the pivot.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ww_s1      <= quat_w * quat_w;
			xx_s1      <= quat_x * quat_x;
			yy_s1      <= quat_y * quat_y;
			zz_s1      <= quat_z * quat_z;
			xy_s1      <= quat_x * quat_y;
			xz_s1      <= quat_x * quat_z;
			yz_s1      <= quat_y * quat_z;
			wx_s1      <= quat_w * quat_x;
			wy_s1      <= quat_w * quat_y;
			wz_s1      <= quat_w * quat_z;
			offs_s1[0] <= (CW+1)'(vec_x) - (CW+1)'(pivot_x);
			offs_s1[1] <= (CW+1)'(vec_y) - (CW+1)'(pivot_y);
			offs_s1[2] <= (CW+1)'(vec_z) - (CW+1)'(pivot_z);
			piv_s1[0]  <= pivot_x;
			piv_s1[1]  <= pivot_y;
			piv_s1[2]  <= pivot_z;
		end
	end

	// Rotation matrix, row-major: entry 3*row + col.
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			mat_s2[0] <= MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
			mat_s2[1] <= (MW'(xy_s1) - MW'(wz_s1)) <<< 1;
			mat_s2[2] <= (MW'(xz_s1) + MW'(wy_s1)) <<< 1;
			mat_s2[3] <= (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
			mat_s2[4] <= MW'(ww_s1) + MW'(yy_s1) - MW'(xx_s1) - MW'(zz_s1);
			mat_s2[5] <= (MW'(yz_s1) - MW'(wx_s1)) <<< 1;
			mat_s2[6] <= (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
			mat_s2[7] <= (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
			mat_s2[8] <= MW'(ww_s1) + MW'(zz_s1) - MW'(xx_s1) - MW'(yy_s1);
			offs_s2   <= offs_s1;
			piv_s2    <= piv_s1;
		end
	end

	assign out_valid = vld_s2;
	assign mat       = mat_s2;
	assign offs      = offs_s2;
	assign piv       = piv_s2;

endmodule

`default_nettype wire

[rtl/core/qrv_mac.sv]
// Stages 3 and 4: matrix-times-offset products, row sums, rounding to Q.16.
// Depends on qrv_pkg.
`default_nettype none

module qrv_mac
	import qrv_pkg::*;
#(
	parameter int QW = 16,
	parameter int CW = 32,
	parameter int MW = 34,
	parameter int SW = 41
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [MW-1:0] mat [9],
	input  wire logic signed [CW:0]   offs [3],
	input  wire logic signed [CW-1:0] piv [3],
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [SW-1:0]      rsum [3],
	output logic signed [CW-1:0]      piv_out [3]
);

	localparam int PW = MW + CW + 1;
	localparam int AW = PW + SUM_GROWTH;
	localparam int FS = 2 * (QW - QUAT_INT_BITS);
	localparam logic [AW-1:0] ROUND_HALF = {{(AW-1){1'b0}}, 1'b1} << (FS - 1);

	logic                 vld_s3, vld_s4;
	logic                 rdy_s3, rdy_s4;
	logic signed [PW-1:0] prod_s3 [9];
	logic signed [CW-1:0] piv_s3 [3];
	logic signed [SW-1:0] rsum_s4 [3];
	logic signed [CW-1:0] piv_s4 [3];
	logic        [AW-1:0] acc [3];

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= in_valid;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			for (int k = 0; k < 9; k++) begin
				prod_s3[k] <= PW'(mat[k]) * PW'(offs[k % 3]);
			end
			piv_s3 <= piv;
		end
	end

	// Add half an LSB, then drop the fraction bits: ties go toward plus infinity.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = AW'(prod_s3[3*r]) + AW'(prod_s3[3*r+1]) + AW'(prod_s3[3*r+2])
				+ ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s4[r] <= acc[r][AW-1:FS];
			end
			piv_s4 <= piv_s3;
		end
	end

	assign out_valid = vld_s4;
	assign rsum      = rsum_s4;
	assign piv_out   = piv_s4;

endmodule

`default_nettype wire

[rtl/core/qrv_out.sv]
// Stage 5: add the pivot back, clamp to the coordinate range, output register.
// Standalone; no package items needed beyond widths passed in.
`default_nettype none

module qrv_out #(
	parameter int CW = 32,
	parameter int SW = 41
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [SW-1:0] rsum [3],
	input  wire logic signed [CW-1:0] piv [3],
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [CW-1:0]      rot [3],
	output logic                      sat
);

	localparam int TW = SW + 1;
	localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	logic                 vld_s5;
	logic                 rdy_s5;
	logic signed [TW-1:0] tot [3];
	logic        [2:0]    ovf;
	logic signed [CW-1:0] clamped [3];
	logic signed [CW-1:0] rot_s5 [3];
	logic                 sat_s5;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign in_ready = rdy_s5;

	// Out of range when the bits above the coordinate's sign bit disagree with it.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tot[r] = TW'(rsum[r]) + TW'(piv[r]);
			ovf[r] = !((&tot[r][TW-1:CW-1]) || !(|tot[r][TW-1:CW-1]));
			if (!ovf[r]) begin
				clamped[r] = tot[r][CW-1:0];
			end else if (tot[r][TW-1]) begin
				clamped[r] = COORD_MIN;
			end else begin
				clamped[r] = COORD_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			rot_s5 <= clamped;
			sat_s5 <= |ovf;
		end
	end

	assign out_valid = vld_s5;
	assign rot       = rot_s5;
	assign sat       = sat_s5;

endmodule

`default_nettype wire

[rtl/core/quaternion_rotate_vector_top.sv]
// Top level of the quaternion vector rotation pipeline.
// Depends on qrv_pkg, qrv_mat, qrv_mac and qrv_out.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle unless stalled:
//   a quaternion quat_w..quat_z (signed Q2.14 at the default width), a point
//   vec_x..vec_z and a pivot pivot_x..pivot_z (signed Q16.16). Output channel
//   (out_valid/out_ready) returns rot_x..rot_z, the point rotated about the
//   pivot by q*v*conj(q), plus a saturated flag when any coordinate clamped.
//   The quaternion is not normalized: a non-unit q scales the offset by |q|^2.
//   Five register stages: quaternion products, rotation matrix, matrix times
//   offset, row sums with rounding, pivot add with clamp. Throughput is one
//   word per clock while out_ready does not stall the pipeline.
//   Each stage advances when the stage after it is empty or moving, so a
//   stall at out_ready fills the bubbles first and then holds every stage;
//   no word is lost or repeated. in_ready can stay high while a finished word
//   waits at the output, as long as an empty stage remains upstream.
//   arst_n clears all stage valid bits at once; the block comes out of reset
//   empty and ready.
`default_nettype none

module quaternion_rotate_vector_top
	import qrv_pkg::*;
#(
	parameter int QUAT_WIDTH  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [QUAT_WIDTH-1:0]  quat_w,
	input  wire logic signed [QUAT_WIDTH-1:0]  quat_x,
	input  wire logic signed [QUAT_WIDTH-1:0]  quat_y,
	input  wire logic signed [QUAT_WIDTH-1:0]  quat_z,
	input  wire logic signed [COORD_WIDTH-1:0] vec_x,
	input  wire logic signed [COORD_WIDTH-1:0] vec_y,
	input  wire logic signed [COORD_WIDTH-1:0] vec_z,
	input  wire logic signed [COORD_WIDTH-1:0] pivot_x,
	input  wire logic signed [COORD_WIDTH-1:0] pivot_y,
	input  wire logic signed [COORD_WIDTH-1:0] pivot_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      rot_x,
	output logic signed [COORD_WIDTH-1:0]      rot_y,
	output logic signed [COORD_WIDTH-1:0]      rot_z,
	output logic                               saturated
);

	// Matrix term width, product width, and width of a rounded row sum.
	localparam int MW = 2 * QUAT_WIDTH + MAT_GROWTH;
	localparam int PW = MW + COORD_WIDTH + 1;
	localparam int SW = PW + SUM_GROWTH - 2 * (QUAT_WIDTH - QUAT_INT_BITS);

	logic                          mat_valid, mat_ready;
	logic signed [MW-1:0]          mat [9];
	logic signed [COORD_WIDTH:0]   offs [3];
	logic signed [COORD_WIDTH-1:0] piv_a [3];
	logic                          mac_valid, mac_ready;
	logic signed [SW-1:0]          rsum [3];
	logic signed [COORD_WIDTH-1:0] piv_b [3];
	logic signed [COORD_WIDTH-1:0] rot [3];

	// Stages 1-2: products of quaternion parts, then the rotation matrix.
	qrv_mat #(
		.QW (QUAT_WIDTH),
		.CW (COORD_WIDTH),
		.MW (MW)
	) u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.pivot_x   (pivot_x),
		.pivot_y   (pivot_y),
		.pivot_z   (pivot_z),
		.out_valid (mat_valid),
		.out_ready (mat_ready),
		.mat       (mat),
		.offs      (offs),
		.piv       (piv_a)
	);

	// Stages 3-4: nine multiplies, then three rounded row sums.
	qrv_mac #(
		.QW (QUAT_WIDTH),
		.CW (COORD_WIDTH),
		.MW (MW),
		.SW (SW)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_ready  (mat_ready),
		.mat       (mat),
		.offs      (offs),
		.piv       (piv_a),
		.out_valid (mac_valid),
		.out_ready (mac_ready),
		.rsum      (rsum),
		.piv_out   (piv_b)
	);

	// Stage 5: pivot add, clamp, and the output register.
	qrv_out #(
		.CW (COORD_WIDTH),
		.SW (SW)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mac_valid),
		.in_ready  (mac_ready),
		.rsum      (rsum),
		.piv       (piv_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rot       (rot),
		.sat       (saturated)
	);

	assign rot_x = rot[0];
	assign rot_y = rot[1];
	assign rot_z = rot[2];

endmodule

`default_nettype wire

[tb/sv/qrv_checker.sv]
// Scoreboard for the quaternion vector rotation pipeline: watches both channels,
// predicts every result word from the accepted input word and compares in order.
// Depends on qrv_pkg for the quaternion format.
`timescale 1ns / 1ps

module qrv_checker
	import qrv_pkg::*;
#(
	parameter int QUAT_WIDTH  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [QUAT_WIDTH-1:0]  quat_w,
	input  logic signed [QUAT_WIDTH-1:0]  quat_x,
	input  logic signed [QUAT_WIDTH-1:0]  quat_y,
	input  logic signed [QUAT_WIDTH-1:0]  quat_z,
	input  logic signed [COORD_WIDTH-1:0] vec_x,
	input  logic signed [COORD_WIDTH-1:0] vec_y,
	input  logic signed [COORD_WIDTH-1:0] vec_z,
	input  logic signed [COORD_WIDTH-1:0] pivot_x,
	input  logic signed [COORD_WIDTH-1:0] pivot_y,
	input  logic signed [COORD_WIDTH-1:0] pivot_z,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [COORD_WIDTH-1:0] rot_x,
	input  logic signed [COORD_WIDTH-1:0] rot_y,
	input  logic signed [COORD_WIDTH-1:0] rot_z,
	input  logic                          saturated,
	output int                            mismatches,
	output int                            pending,
	output int                            compared,
	output int                            clamped
);

	// fraction bits of a matrix term: product of two quaternion parts
	localparam int MAT_FRAC = 2 * (QUAT_WIDTH - QUAT_INT_BITS);

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic                          sat;
	} rot_result_t;

	rot_result_t expected_rot[$];
	rot_result_t want;
	int n_mismatch = 0;
	int n_pending  = 0;
	int n_compared = 0;
	int n_clamped  = 0;

	assign mismatches = n_mismatch;
	assign pending    = n_pending;
	assign compared   = n_compared;
	assign clamped    = n_clamped;

	// Rotation matrix of q applied to (v - pivot), one rounding, pivot added back, clamp.
	function automatic rot_result_t rotate_about_pivot(
		input logic signed [QUAT_WIDTH-1:0]  qw, qx, qy, qz,
		input logic signed [COORD_WIDTH-1:0] vx, vy, vz, px, py, pz
	);
		wide_t w, x, y, z, acc, hi_lim, lo_lim;
		wide_t m[3][3];
		wide_t d[3];
		wide_t p[3];
		logic signed [COORD_WIDTH-1:0] res[3];
		rot_result_t r;
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		d[0] = vx;
		d[1] = vy;
		d[2] = vz;
		for (int i = 0; i < 3; i++)
			d[i] = d[i] - p[i];
		m[0][0] = w*w + x*x - y*y - z*z;
		m[1][1] = w*w + y*y - x*x - z*z;
		m[2][2] = w*w + z*z - x*x - y*y;
		m[0][1] = (x*y - w*z) <<< 1;
		m[1][0] = (x*y + w*z) <<< 1;
		m[0][2] = (x*z + w*y) <<< 1;
		m[2][0] = (x*z - w*y) <<< 1;
		m[1][2] = (y*z - w*x) <<< 1;
		m[2][1] = (y*z + w*x) <<< 1;
		hi_lim = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo_lim = -hi_lim - 1;
		r.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0]*d[0] + m[i][1]*d[1] + m[i][2]*d[2];
			// round half up, then drop the matrix fraction bits
			acc = (acc + (wide_t'(1) <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
			acc = acc + p[i];
			if (acc > hi_lim) begin
				acc = hi_lim;
				r.sat = 1'b1;
			end else if (acc < lo_lim) begin
				acc = lo_lim;
				r.sat = 1'b1;
			end
			res[i] = acc[COORD_WIDTH-1:0];
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
		n_mismatch++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// check the outgoing word first; a word accepted now cannot leave this cycle
			if (out_valid && out_ready) begin
				if (expected_rot.size() == 0) begin
					report_mismatch("result word with nothing pending, rot_x",
						longint'(rot_x), longint'(0));
				end else begin
					want = expected_rot.pop_front();
					if (rot_x !== want.x)
						report_mismatch("rot_x", longint'(rot_x), longint'(want.x));
					if (rot_y !== want.y)
						report_mismatch("rot_y", longint'(rot_y), longint'(want.y));
					if (rot_z !== want.z)
						report_mismatch("rot_z", longint'(rot_z), longint'(want.z));
					if (saturated !== want.sat)
						report_mismatch("saturated", longint'(saturated),
							longint'(want.sat));
					n_compared++;
					if (want.sat)
						n_clamped++;
				end
			end
			if (in_valid && in_ready)
				expected_rot.push_back(rotate_about_pivot(quat_w, quat_x, quat_y, quat_z,
					vec_x, vec_y, vec_z, pivot_x, pivot_y, pivot_z));
			n_pending = expected_rot.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench top for quaternion_rotate_vector_top: drives directed and random
// words with random idling and stalls, and gives the verdict.
// Depends on qrv_pkg, the block and qrv_checker.
`timescale 1ns / 1ps

module tb;

	localparam int QW = 16;
	localparam int CW = 32;

	// 1.0 in Q2.14, and cos(45 deg) in the same format
	localparam int QONE  = 16384;
	localparam int COS45 = 11585;
	// 1.0 in Q16.16
	localparam int CONE  = 65536;
	localparam int CMAX  = 32'sh7fff_ffff;
	localparam int CMIN  = 32'sh8000_0000;
	localparam int QMAX  = 32767;
	localparam int QMIN  = -32768;

	// five register stages; the drain wait covers them with margin
	localparam int PIPE_DEPTH   = 5;
	localparam int LIMIT_CYCLES = 200000;
	localparam int LONG_HOLD    = 300;

	typedef struct {
		logic signed [QW-1:0] qw, qx, qy, qz;
		logic signed [CW-1:0] vx, vy, vz, px, py, pz;
	} point_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic signed [QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [CW-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic signed [CW-1:0] pivot_x = '0, pivot_y = '0, pivot_z = '0;

	logic                 in_ready;
	logic                 out_valid;
	logic signed [CW-1:0] rot_x, rot_y, rot_z;
	logic                 saturated;

	int mismatches, pending, compared, clamped;

	// run state; idle_on and hold_len are shared between the stimulus and the receiver process
	bit idle_on  = 1'b1;
	int hold_len = 0;
	int cycles   = 0;
	int words_sent = 0;
	int directed_count = 0;

	point_word_t directed_words[$];

	quaternion_rotate_vector_top #(
		.QUAT_WIDTH  (QW),
		.COORD_WIDTH (CW)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.pivot_x   (pivot_x),
		.pivot_y   (pivot_y),
		.pivot_z   (pivot_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.rot_z     (rot_z),
		.saturated (saturated)
	);

	qrv_checker #(
		.QUAT_WIDTH  (QW),
		.COORD_WIDTH (CW)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.pivot_x    (pivot_x),
		.pivot_y    (pivot_y),
		.pivot_z    (pivot_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rot_x      (rot_x),
		.rot_y      (rot_y),
		.rot_z      (rot_z),
		.saturated  (saturated),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared),
		.clamped    (clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stall bursts while idling is on, plus the long hold-off
	// that the stimulus requests through hold_len. The hold is counted here so
	// that the sender keeps offering words and the pipeline backs up.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	function automatic point_word_t make_word(input int qw, qx, qy, qz, vx, vy, vz, px, py, pz);
		point_word_t wd;
		wd.qw = QW'(qw);
		wd.qx = QW'(qx);
		wd.qy = QW'(qy);
		wd.qz = QW'(qz);
		wd.vx = vx;
		wd.vy = vy;
		wd.vz = vz;
		wd.px = px;
		wd.py = py;
		wd.pz = pz;
		return wd;
	endfunction

	function automatic int edge_value(input int lo, input int hi);
		case ($urandom_range(0, 4))
			0: return lo;
			1: return hi;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic int small_coord();
		return int'($urandom_range(0, 1 << 21)) - (1 << 20);
	endfunction

	// Mix of full-range words (mostly clamping), in-range words, pure axis
	// rotations, origin rotations and extreme-value words.
	function automatic point_word_t random_word();
		point_word_t wd;
		int kind, c, s, sgn;
		kind = $urandom_range(0, 9);
		wd.qw = QW'($urandom);
		wd.qx = QW'($urandom);
		wd.qy = QW'($urandom);
		wd.qz = QW'($urandom);
		wd.vx = $urandom;
		wd.vy = $urandom;
		wd.vz = $urandom;
		wd.px = $urandom;
		wd.py = $urandom;
		wd.pz = $urandom;
		case (kind)
			4, 5, 6: begin
				wd.qw = QW'(int'($urandom_range(0, 2 * QONE)) - QONE);
				wd.qx = QW'(int'($urandom_range(0, 2 * QONE)) - QONE);
				wd.qy = QW'(int'($urandom_range(0, 2 * QONE)) - QONE);
				wd.qz = QW'(int'($urandom_range(0, 2 * QONE)) - QONE);
				wd.vx = small_coord();
				wd.vy = small_coord();
				wd.vz = small_coord();
				wd.px = small_coord();
				wd.py = small_coord();
				wd.pz = small_coord();
			end
			7: begin
				wd.px = 0;
				wd.py = 0;
				wd.pz = 0;
			end
			8: begin
				wd.qw = QW'(edge_value(QMIN, QMAX));
				wd.qx = QW'(edge_value(QMIN, QMAX));
				wd.qy = QW'(edge_value(QMIN, QMAX));
				wd.qz = QW'(edge_value(QMIN, QMAX));
				wd.vx = edge_value(CMIN, CMAX);
				wd.vy = edge_value(CMIN, CMAX);
				wd.vz = edge_value(CMIN, CMAX);
				wd.px = edge_value(CMIN, CMAX);
				wd.py = edge_value(CMIN, CMAX);
				wd.pz = edge_value(CMIN, CMAX);
			end
			9: begin
				// unit quaternion about one axis
				c = $urandom_range(0, QONE);
				s = $rtoi($sqrt(real'(QONE * QONE - c * c)));
				sgn = $urandom_range(0, 1) ? s : -s;
				wd.qw = QW'($urandom_range(0, 1) ? c : -c);
				wd.qx = '0;
				wd.qy = '0;
				wd.qz = '0;
				case ($urandom_range(0, 2))
					0: wd.qx = QW'(sgn);
					1: wd.qy = QW'(sgn);
					default: wd.qz = QW'(sgn);
				endcase
				wd.vx = small_coord();
				wd.vy = small_coord();
				wd.vz = small_coord();
				wd.px = small_coord();
				wd.py = small_coord();
				wd.pz = small_coord();
			end
			default: ;
		endcase
		return wd;
	endfunction

	// Offer one word and hold it until the handshake; returns at the accepting edge, or after a random idle gap.
	task automatic send_word(input point_word_t wd);
		in_valid <= 1'b1;
		quat_w   <= wd.qw;
		quat_x   <= wd.qx;
		quat_y   <= wd.qy;
		quat_z   <= wd.qz;
		vec_x    <= wd.vx;
		vec_y    <= wd.vy;
		vec_z    <= wd.vz;
		pivot_x  <= wd.px;
		pivot_y  <= wd.py;
		pivot_z  <= wd.pz;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		words_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_word(random_word());
	endtask

	initial begin
		// identity, zero and sign-flipped quaternions
		directed_words.push_back(make_word(QONE, 0, 0, 0, CONE, -2 * CONE, 3 * CONE, 0, 0, 0));
		directed_words.push_back(make_word(0, 0, 0, 0, 123456, -7, 99, 5 * CONE, -CONE, 42));
		directed_words.push_back(make_word(-QONE, 0, 0, 0, 7, -CONE, 1234567, 0, 0, 0));
		// half turn about x, quarter turns about z, y and x (z and x with off-origin pivots)
		directed_words.push_back(make_word(0, QONE, 0, 0, CONE, CONE, CONE, 0, 0, 0));
		directed_words.push_back(make_word(COS45, 0, 0, COS45, 2 * CONE, 0, 0, CONE, CONE, 0));
		directed_words.push_back(make_word(COS45, 0, COS45, 0, 0, 0, 2 * CONE, 0, 0, 0));
		directed_words.push_back(make_word(COS45, COS45, 0, 0, 0, 3 * CONE, -CONE, 0, CONE, 0));
		// ties on the rounding step: half-way values go toward plus infinity
		directed_words.push_back(make_word(8192, 0, 0, 0, 2, -2, 1, 0, 0, 0));
		directed_words.push_back(make_word(8192, 0, 0, 0, 6, -6, 3, 0, 0, 0));
		// non-unit quaternion scales the offset by its squared norm
		directed_words.push_back(make_word(2 * QONE, 0, 0, 0, 1000 * CONE, -1000 * CONE, 1, 0, 0, 0));
		// overflow above and below the coordinate range
		directed_words.push_back(make_word(QMAX, 0, 0, 0, CMAX, CMIN, 0, 0, 0, 0));
		directed_words.push_back(make_word(QMIN, QMIN, QMIN, QMIN, CMAX, CMAX, CMAX,
			CMIN, CMIN, CMIN));
		directed_words.push_back(make_word(QMAX, QMAX, QMAX, QMAX, CMAX, CMAX, CMAX,
			CMAX, CMAX, CMAX));
		directed_words.push_back(make_word(QMAX, QMIN, QMAX, QMIN, CMIN, CMAX, CMIN,
			CMAX, CMIN, CMAX));
		// widest offsets, exact at the identity and mirrored by a half turn
		directed_words.push_back(make_word(QONE, 0, 0, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
		directed_words.push_back(make_word(0, QONE, 0, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
		directed_words.push_back(make_word(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0));
		directed_words.push_back(make_word(QONE, QONE, QONE, QONE, 32'sh4000_0000,
			32'sh7fff_0000, -32'sh0001_0000, 0, 0, 0));
		directed_count = directed_words.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_words[i])
			send_word(directed_words[i]);
		drain_results();

		send_random(180);

		// hold the output long enough for the pipeline to fill and stall the input
		hold_len = LONG_HOLD;
		send_random(30);
		drain_results();

		send_random(220);

		// last stretch at full rate on both sides
		idle_on = 1'b0;
		send_random(120);
		drain_results();

		$display("run covered %0d words (%0d directed), %0d results compared, %0d clamped",
			words_sent, directed_count, compared, clamped);
		$display("with random idling, a %0d-cycle output hold-off and full-rate streaming",
			LONG_HOLD);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/qrv_pkg.sv
rtl/core/qrv_mat.sv
rtl/core/qrv_mac.sv
rtl/core/qrv_out.sv
rtl/core/quaternion_rotate_vector_top.sv
tb/sv/qrv_checker.sv
tb/sv/tb.sv
